/* src/radar_target_frame_parser_unit_macros.svh */
// Assertion helpers for the radar target frame parser.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef RADAR_TARGET_FRAME_PARSER_UNIT_MACROS_SVH
`define RADAR_TARGET_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define RTFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rtfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtfp_pkg;

    // Frame geometry
    localparam int TARGET_SLOTS = 3;
    localparam int BUFFER_BYTES = 32;
    localparam int GROUP_BYTES  = 8;
    localparam int HEADER_BYTES = 4;
    localparam int SCAN_BYTES   = TARGET_SLOTS * GROUP_BYTES;

    localparam int BUF_AW  = $clog2(BUFFER_BYTES);
    localparam int WPOS_W  = $clog2(BUFFER_BYTES + 1);
    localparam int SLOT_IW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;

    // Result payload: pos_x, pos_y, velocity, resolution, prev_x, prev_y, target_count
    localparam int TDATA_BITS = 6 * 16 + 2;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
    localparam int TUSER_W    = 3;

    typedef logic [BUF_AW-1:0]  t_buf_addr;
    typedef logic [WPOS_W-1:0]  t_wpos;
    typedef logic [SLOT_IW-1:0] t_slot_idx;

    localparam t_buf_addr  SCAN_LAST = t_buf_addr'(SCAN_BYTES - 1);
    localparam t_slot_idx  SLOT_LAST = t_slot_idx'(TARGET_SLOTS - 1);
    localparam logic [1:0] HDR_LAST  = 2'(HEADER_BYTES - 1);
    localparam logic [2:0] GRP_LAST  = 3'(GROUP_BYTES - 1);
    localparam logic [15:0] SM_POSITIVE = 16'h8000;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEADER = 1'b0,
        CFG_FOOTER = 1'b1
    } t_cfg_reg;

    // Frame buffer write request
    typedef struct packed {
        logic      en;
        t_buf_addr addr;
        logic [7:0] data;
    } t_buf_wr;

    // Sign-magnitude (set sign bit = positive) to two's complement
    function automatic logic [15:0] sm_decode(input logic [15:0] w);
        logic [15:0] mag;
        mag = w & ~SM_POSITIVE;
        return ((w & SM_POSITIVE) != 16'h0000) ? mag : (~mag + 16'd1);
    endfunction

endpackage

`default_nettype wire

/* src/rtfp_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtfp_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rtfp_pkg::t_buf_wr  i_wr,
    input  wire rtfp_pkg::t_buf_addr i_rd_addr,
    output logic [7:0]              o_rd_data
);

    logic [7:0]                        mem [rtfp_pkg::BUFFER_BYTES];
    logic [rtfp_pkg::BUFFER_BYTES-1:0] r_vld;
    logic [7:0]                        r_rd_raw;
    logic                              r_rd_vld;

    // Write the byte array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Track written entries; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_raw <= mem[i_rd_addr];
        r_rd_vld <= r_vld[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : 8'h00;

endmodule

`default_nettype wire

/* src/radar_target_frame_parser_unit.sv */
// Radar target frame parser.
// Slave stream: one received byte per transfer on i_s_axis_tdata. Bytes are matched
// against the four-byte header (config register 0), then stored in a 32-byte frame
// buffer until the two-byte footer (config register 1) completes the frame.
// Master stream: on the footer, one result per target slot, slot 0 first, tlast on
// the final slot. Each result carries the decoded position, speed, resolution, the
// slot's previous position and the frame's present-target count.
// Timing: ordinary bytes are accepted while the parser is idle. A footer byte starts a
// sequencer that reads the buffer one byte per cycle through its single registered
// read port: a presence scan over the 24 slot bytes, then, per slot, a load of the
// slot's 8 bytes and a decode into the output register. Each slot after the first is
// loaded only after the previous result is taken.
// tready on the slave side is low until the final result is taken.
// A stalled receiver simply holds the current result in the output register; the
// sequencer waits for it.
// Config writes are always accepted (ready stays high) and must only happen while idle.
// Reset (synchronous, active low) clears the match state, both config registers,
// the stored slot positions and the buffer contents, and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module radar_target_frame_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Received bytes
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // Slot results
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] velocity, [63:48] resolution,
    // [79:64] prev_x, [95:80] prev_y, [97:96] target_count, [103:98] zero
    output logic [rtfp_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic [rtfp_pkg::TUSER_W-1:0] o_m_axis_tuser,  // [1:0] slot, [2] present
    output logic             o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_DEC,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [31:0]                     r_header;
    logic [15:0]                     r_footer;
    logic [1:0]                      r_hdr_pos;
    logic                            r_ftr_pos;
    logic                            r_in_frame;
    rtfp_pkg::t_wpos                 r_wr_pos;
    rtfp_pkg::t_buf_addr             r_cnt;
    logic                            r_issue;
    logic                            r_pend;
    rtfp_pkg::t_buf_addr             r_rd_idx;
    logic [7:0]                      r_acc;
    logic [rtfp_pkg::TARGET_SLOTS-1:0] r_pres;
    logic [63:0]                     r_grp;
    rtfp_pkg::t_slot_idx             r_slot;
    logic [15:0]                     r_slot_x [rtfp_pkg::TARGET_SLOTS];
    logic [15:0]                     r_slot_y [rtfp_pkg::TARGET_SLOTS];
    logic                            r_o_valid;
    logic [rtfp_pkg::TDATA_W-1:0]    r_o_data;
    logic [rtfp_pkg::TUSER_W-1:0]    r_o_user;
    logic                            r_o_last;

    logic                            w_in_acc;
    logic                            w_cfg_acc;
    logic [7:0]                      w_hdr_want;
    logic [7:0]                      w_ftr_want;
    logic [7:0]                      w_rd_data;
    rtfp_pkg::t_buf_wr               w_wr;
    rtfp_pkg::t_slot_idx             w_rd_slot;
    rtfp_pkg::t_slot_idx             w_slot_nx;
    logic                            w_present;
    logic [15:0]                     w_x;
    logic [15:0]                     w_y;
    logic [15:0]                     w_vel;
    logic [15:0]                     w_res;
    logic [1:0]                      w_count;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;
    assign o_m_axis_tlast  = r_o_last;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;

    // Expected header and footer bytes at the current match position
    assign w_hdr_want = r_header[{r_hdr_pos, 3'b000} +: 8];
    assign w_ftr_want = r_footer[{r_ftr_pos, 3'b000} +: 8];

    // Store in-frame bytes until the buffer is full
    always_comb begin
        w_wr.en   = w_in_acc && r_in_frame && (r_wr_pos < rtfp_pkg::BUFFER_BYTES);
        w_wr.addr = r_wr_pos[rtfp_pkg::BUF_AW-1:0];
        w_wr.data = i_s_axis_tdata;
    end

    rtfp_buf u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (r_cnt),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_slot = rtfp_pkg::t_slot_idx'(r_rd_idx >> 3);
    assign w_slot_nx = r_slot + 1'b1;

    // Decode the loaded slot group
    assign w_present = r_pres[r_slot];
    assign w_x     = w_present ? rtfp_pkg::sm_decode(r_grp[15:0])  : 16'h0000;
    assign w_y     = w_present ? rtfp_pkg::sm_decode(r_grp[31:16]) : 16'h0000;
    assign w_vel   = w_present ? rtfp_pkg::sm_decode(r_grp[47:32]) : 16'h0000;
    assign w_res   = w_present ? r_grp[63:48] : 16'h0000;
    assign w_count = 2'($countones(r_pres));

    // Parser and result sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_header   <= '0;
            r_footer   <= '0;
            r_hdr_pos  <= '0;
            r_ftr_pos  <= 1'b0;
            r_in_frame <= 1'b0;
            r_wr_pos   <= '0;
            r_cnt      <= '0;
            r_issue    <= 1'b0;
            r_pend     <= 1'b0;
            r_pres     <= '0;
            r_slot     <= '0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < rtfp_pkg::TARGET_SLOTS; i++) begin
                r_slot_x[i] <= '0;
                r_slot_y[i] <= '0;
            end
        end else begin
            // Configuration writes
            if (w_cfg_acc) begin
                case (rtfp_pkg::t_cfg_reg'(i_cfg_index))
                    rtfp_pkg::CFG_HEADER: r_header <= i_cfg_data;
                    rtfp_pkg::CFG_FOOTER: r_footer <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && !r_in_frame) begin
                        // Hunt for the header
                        if (i_s_axis_tdata == w_hdr_want) begin
                            if (r_hdr_pos == rtfp_pkg::HDR_LAST) begin
                                r_hdr_pos  <= '0;
                                r_in_frame <= 1'b1;
                                r_wr_pos   <= '0;
                            end else begin
                                r_hdr_pos <= r_hdr_pos + 1'b1;
                            end
                        end else begin
                            r_hdr_pos <= '0;
                        end
                    end else if (w_in_acc) begin
                        // Advance the write position and watch for the footer
                        if (r_wr_pos < rtfp_pkg::BUFFER_BYTES &&
                            !(r_ftr_pos && i_s_axis_tdata == w_ftr_want)) begin
                            r_wr_pos <= r_wr_pos + 1'b1;
                        end
                        if (i_s_axis_tdata != w_ftr_want) begin
                            r_ftr_pos <= 1'b0;
                        end else if (!r_ftr_pos) begin
                            r_ftr_pos <= 1'b1;
                        end else begin
                            r_ftr_pos  <= 1'b0;
                            r_in_frame <= 1'b0;
                            r_hdr_pos  <= '0;
                            r_wr_pos   <= '0;
                            r_cnt      <= '0;
                            r_issue    <= 1'b1;
                            r_acc      <= '0;
                            r_state    <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    // Walk all slot groups and OR their bytes
                    if (r_issue) begin
                        if (r_cnt == rtfp_pkg::SCAN_LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    r_pend   <= r_issue;
                    r_rd_idx <= r_cnt;
                    if (r_pend) begin
                        if (r_rd_idx[2:0] == rtfp_pkg::GRP_LAST) begin
                            r_pres[w_rd_slot] <= ((r_acc | w_rd_data) != 8'h00);
                            r_acc <= '0;
                        end else begin
                            r_acc <= r_acc | w_rd_data;
                        end
                        if (r_rd_idx == rtfp_pkg::SCAN_LAST) begin
                            r_slot  <= '0;
                            r_cnt   <= '0;
                            r_issue <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end

                S_LOAD: begin
                    // Gather the current slot's eight bytes
                    if (r_issue) begin
                        if (r_cnt[2:0] == rtfp_pkg::GRP_LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    r_pend   <= r_issue;
                    r_rd_idx <= r_cnt;
                    if (r_pend) begin
                        r_grp[{r_rd_idx[2:0], 3'b000} +: 8] <= w_rd_data;
                        if (r_rd_idx[2:0] == rtfp_pkg::GRP_LAST) begin
                            r_state <= S_DEC;
                        end
                    end
                end

                S_DEC: begin
                    // Fill the output register and update the stored position
                    r_o_data <= rtfp_pkg::TDATA_W'({w_count, r_slot_y[r_slot],
                                                    r_slot_x[r_slot], w_res, w_vel,
                                                    w_y, w_x});
                    r_o_user <= {w_present, 2'(r_slot)};
                    r_o_last <= (r_slot == rtfp_pkg::SLOT_LAST);
                    r_o_valid <= 1'b1;
                    if (w_present) begin
                        r_slot_x[r_slot] <= w_x;
                        r_slot_y[r_slot] <= w_y;
                    end
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    // Hold the result until transfer, then move to the next slot
                    if (i_m_axis_tready) begin
                        r_o_valid <= 1'b0;
                        if (r_slot == rtfp_pkg::SLOT_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= w_slot_nx;
                            r_cnt   <= rtfp_pkg::t_buf_addr'(w_slot_nx) << 3;
                            r_issue <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "radar_target_frame_parser_unit_macros.svh"

    `RTFP_ASSERT_NOW(a_busy_while_result, o_m_axis_tvalid, !o_s_axis_tready, "byte taken while a result waits")
    `RTFP_ASSERT_NOW(a_last_on_final_slot, o_m_axis_tvalid && o_m_axis_tlast, r_slot == rtfp_pkg::SLOT_LAST, "tlast on a slot other than the final one")
    `RTFP_ASSERT_NEXT(a_ready_after_frame, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, o_s_axis_tready, "not ready after the final result")
    `RTFP_ASSERT_NOW(a_wr_pos_bound, r_in_frame, r_wr_pos <= rtfp_pkg::BUFFER_BYTES, "write position past the buffer")

endmodule

`default_nettype wire

/* tb/sv/radar_target_frame_parser_unit_tb.sv */
`timescale 1ns / 1ps

module radar_target_frame_parser_unit_tb;
    import rtfp_pkg::*;

    localparam logic [31:0] LINK_HEADER    = 32'hD4C3_B2A1;
    localparam logic [15:0] LINK_FOOTER    = 16'h5EE5;
    localparam int          RANDOM_BYTES   = 270;
    localparam int          RANDOM_RESULTS = 18;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          STALL_LIMIT    = 3000;

    typedef struct packed {
        logic [1:0]  slot;
        logic        present;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] velocity;
        logic [15:0] resolution;
        logic [15:0] prev_x;
        logic [15:0] prev_y;
        logic [1:0]  target_count;
        logic        is_last;
    } slot_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    t_cfg_reg cfg_index;
    logic [31:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic m_tlast;

    // Predicted parser state
    logic [31:0] hdr_word;
    logic [15:0] ftr_word;
    int unsigned hdr_match;
    int unsigned ftr_match;
    int unsigned fill_pos;
    bit          framing;
    logic [7:0]  frame_mem [BUFFER_BYTES];
    logic [15:0] last_x [TARGET_SLOTS];
    logic [15:0] last_y [TARGET_SLOTS];

    slot_result_t pending_results[$];

    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned results_seen;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_req;

    radar_target_frame_parser_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Sign bit set means positive; magnitude in the low 15 bits
    function automatic logic [15:0] sm_to_int(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] mag;
        mag = {1'b0, hi[6:0], lo};
        return hi[7] ? mag : (16'h0000 - mag);
    endfunction

    function automatic void reset_prediction();
        hdr_word  = '0;
        ftr_word  = '0;
        hdr_match = 0;
        ftr_match = 0;
        fill_pos  = 0;
        framing   = 1'b0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        foreach (last_x[i]) begin
            last_x[i] = '0;
            last_y[i] = '0;
        end
    endfunction

    // Advance the parser state by one received byte; queue slot results on a footer
    function automatic void predict_byte(input logic [7:0] b);
        logic [7:0]   want;
        logic [7:0]   acc;
        bit           seen [TARGET_SLOTS];
        int unsigned  hits;
        int unsigned  base;
        slot_result_t r;
        hits = 0;
        if (!framing) begin
            want = hdr_word[hdr_match*8 +: 8];
            if (b == want) begin
                hdr_match++;
                if (hdr_match == HEADER_BYTES) begin
                    hdr_match = 0;
                    framing   = 1'b1;
                    fill_pos  = 0;
                end
            end else begin
                hdr_match = 0;
            end
            return;
        end
        if (fill_pos < BUFFER_BYTES) begin
            frame_mem[fill_pos] = b;
            fill_pos++;
        end
        want = ftr_word[ftr_match*8 +: 8];
        if (b != want) begin
            ftr_match = 0;
            return;
        end
        ftr_match++;
        if (ftr_match < 2) return;

        // Presence scan over every slot group first, then decode in slot order
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            acc = '0;
            for (int k = 0; k < GROUP_BYTES; k++) acc |= frame_mem[s*GROUP_BYTES + k];
            seen[s] = (acc != 8'h00);
            if (seen[s]) hits++;
        end
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            base           = s * GROUP_BYTES;
            r              = '0;
            r.slot         = 2'(s);
            r.present      = seen[s];
            r.prev_x       = last_x[s];
            r.prev_y       = last_y[s];
            r.target_count = 2'(hits);
            r.is_last      = (s == TARGET_SLOTS - 1);
            if (seen[s]) begin
                r.pos_x      = sm_to_int(frame_mem[base], frame_mem[base+1]);
                r.pos_y      = sm_to_int(frame_mem[base+2], frame_mem[base+3]);
                r.velocity   = sm_to_int(frame_mem[base+4], frame_mem[base+5]);
                r.resolution = {frame_mem[base+7], frame_mem[base+6]};
                last_x[s]    = r.pos_x;
                last_y[s]    = r.pos_y;
            end
            pending_results.push_back(r);
        end
        framing   = 1'b0;
        hdr_match = 0;
        ftr_match = 0;
        fill_pos  = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Register write; only called while the parser is idle
    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HEADER: hdr_word = value;
            CFG_FOOTER: ftr_word = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_framing(input logic [31:0] hdr, input logic [15:0] ftr);
        write_reg(CFG_HEADER, hdr);
        write_reg(CFG_FOOTER, {16'h0000, ftr});
    endtask

    // Offer one byte, hold it until the transfer, then predict
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and wait for every pending result plus the sequencer tail
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_list(input logic [7:0] bytes_in[$]);
        foreach (bytes_in[i]) push_byte(bytes_in[i]);
    endtask

    // One frame with random slot groups; when not clean, add noise, bad
    // header bytes, short or overlong bodies and broken footers
    task automatic send_frame(input bit clean);
        logic [7:0]  body[$];
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  b;
        bit          absent;
        int unsigned mode;
        int unsigned cut;
        if (!clean && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        for (int k = 0; k < HEADER_BYTES; k++) begin
            b = hdr_word[k*8 +: 8];
            if (!clean && $urandom_range(0, 19) == 0) b = 8'($urandom);
            push_byte(b);
        end
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            absent = ($urandom_range(0, 3) == 0);
            for (int fld = 0; fld < 4; fld++) begin
                lo = 8'($urandom);
                hi = 8'($urandom);
                if (absent) begin
                    lo = 8'h00;
                    hi = 8'h00;
                end else if (fld < 3 && $urandom_range(0, 7) == 0) begin
                    // zero magnitude with either sign
                    lo = 8'h00;
                    hi = {1'($urandom_range(0, 1)), 7'h00};
                end
                body.push_back(lo);
                body.push_back(hi);
            end
        end
        mode = clean ? 2 : $urandom_range(0, 9);
        if (mode == 0) begin
            cut = $urandom_range(0, SCAN_BYTES - 1);
            while (body.size() > cut) void'(body.pop_back());
        end else if (mode == 1) begin
            repeat ($urandom_range(1, 16)) body.push_back(8'($urandom));
        end
        push_list(body);
        if (!clean && $urandom_range(0, 9) == 0) begin
            push_byte(ftr_word[7:0]);
            push_byte(8'($urandom));
        end
        push_byte(ftr_word[7:0]);
        push_byte(ftr_word[15:8]);
    endtask

    // Registers still at reset: zero header and footer, all slots absent
    task automatic test_reset_registers();
        push_list('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        settle_block();
        program_framing(LINK_HEADER, LINK_FOOTER);
    endtask

    // A repeated first header byte breaks the match and is not checked again
    task automatic test_header_resync();
        push_list('{8'hA1, 8'hA1, 8'hB2, 8'hC3, 8'hD4});
        settle_block();
    endtask

    // Negative zero, both magnitude extremes, a footer restart, an absent slot
    task automatic test_sign_and_absent();
        push_list('{8'hA1, 8'hB2, 8'hC3, 8'hD4,
                    8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                    8'hE5, 8'hE5, 8'h5E, 8'hE5, 8'h5E});
        settle_block();
    endtask

    // Header bytes inside a frame are stored; unwritten positions stay stale
    task automatic test_stale_buffer();
        push_list('{8'hA1, 8'hB2, 8'hC3, 8'hD4, 8'hA1, 8'hB2, 8'hC3, 8'hD4,
                    8'hE5, 8'h5E});
        settle_block();
    endtask

    // Mostly well-formed frames, new framing words every four frames
    task automatic test_random_frames();
        int unsigned stop_bytes;
        int unsigned results_start;
        int unsigned frames;
        logic [31:0] hdr;
        logic [15:0] ftr;
        stop_bytes    = bytes_sent + RANDOM_BYTES;
        results_start = results_seen;
        frames        = 0;
        while (bytes_sent < stop_bytes || results_seen - results_start < RANDOM_RESULTS) begin
            if (frames % 4 == 0) begin
                settle_block();
                case ((frames / 4) % 4)
                    0: begin hdr = '1; ftr = '1; end
                    1: begin hdr = '0; ftr = '0; end
                    default: begin hdr = $urandom; ftr = 16'($urandom); end
                endcase
                tx_calm = ((frames / 4) % 3 == 2);
                rx_calm = tx_calm;
                program_framing(hdr, ftr);
            end
            send_frame(1'b0);
            frames++;
        end
        settle_block();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Receiver stalls long while frames keep coming, so the input backs up
    task automatic test_receiver_holdoff();
        program_framing(LINK_HEADER, LINK_FOOTER);
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        repeat (3) send_frame(1'b1);
        settle_block();
        tx_calm = 1'b0;
    endtask

    // Result ready: random stalls, calm stretches, and one long hold-off
    initial begin : result_sink
        int unsigned stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else if (stall == 0 && !rx_calm && $urandom_range(0, 3) == 0) begin
                stall = idle_len();
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk) begin : result_check
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", {29'h0, m_tuser}, '0);
            end else begin
                want = pending_results.pop_front();
                check_field("slot",         m_tuser[1:0],    want.slot);
                check_field("present",      m_tuser[2],      want.present);
                check_field("pos_x",        m_tdata[15:0],   want.pos_x);
                check_field("pos_y",        m_tdata[31:16],  want.pos_y);
                check_field("velocity",     m_tdata[47:32],  want.velocity);
                check_field("resolution",   m_tdata[63:48],  want.resolution);
                check_field("prev_x",       m_tdata[79:64],  want.prev_x);
                check_field("prev_y",       m_tdata[95:80],  want.prev_y);
                check_field("target_count", m_tdata[97:96],  want.target_count);
                check_field("tlast",        m_tlast,         want.is_last);
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : run
        mismatches   = 0;
        bytes_sent   = 0;
        results_seen = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        hold_req     = 1'b0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HEADER;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        reset_prediction();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_header_resync();
        test_sign_and_absent();
        test_stale_buffer();
        test_random_frames();
        test_receiver_holdoff();

        settle_block();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
